@@ sv/rgbct_pkg.sv @@
// Constants, types and arithmetic helpers for the RGB color tween pipeline.
package rgbct_pkg;

  localparam int FRAC_BITS = 15;
  localparam int VW        = FRAC_BITS + 1;   // holds 0..ONE
  localparam int PW        = 2 * VW;          // product width
  localparam int FW        = 16;              // port field width
  localparam int NS        = 10;              // pipeline stages
  localparam int ONE_I     = 1 << FRAC_BITS;

  typedef logic [VW-1:0]          unit_t;
  typedef logic [PW-1:0]          prod_t;
  typedef logic signed [VW+3:0]   wide_t;
  typedef logic [2:0][VW-1:0]     trio_t;     // [0] red, [1] green, [2] blue

  localparam unit_t ONE    = unit_t'(ONE_I);
  localparam prod_t HALF_P = prod_t'(ONE_I / 2);
  localparam wide_t ONE_W  = wide_t'(ONE_I);

  // k/6 of the wheel, rounded
  localparam unit_t SIXTH1 = unit_t'((1 * ONE_I + 3) / 6);
  localparam unit_t SIXTH2 = unit_t'((2 * ONE_I + 3) / 6);
  localparam unit_t SIXTH3 = unit_t'((3 * ONE_I + 3) / 6);
  localparam unit_t SIXTH4 = unit_t'((4 * ONE_I + 3) / 6);
  localparam unit_t SIXTH5 = unit_t'((5 * ONE_I + 3) / 6);

  // floor(y/6) as (y*M) >> SH, exact for y < 2^VW
  localparam int    DIV6_SH = VW + 2;
  localparam int    DIV6_M  = ((1 << DIV6_SH) + 5) / 6;
  localparam unit_t DIV6_MV = unit_t'(DIV6_M);

  // operand select for the six-case rule; hue = floor(y/6) + off
  typedef struct packed {
    unit_t y;
    unit_t off;
    unit_t s;
    unit_t v;
  } hsel_t;

  function automatic unit_t sat_in(logic [FW-1:0] x);
    if (32'(x) > 32'(ONE_I)) return ONE;
    return unit_t'(x);
  endfunction

  function automatic hsel_t hsv_select(unit_t r, unit_t g, unit_t b);
    hsel_t o;
    unit_t x;
    if (r >= g) begin
      o.v = r;
      if (b > r) begin
        o.v = b; o.s = ONE - g; x = r; o.off = SIXTH4;
      end else if (b > g) begin
        o.s = ONE - g; x = ONE - b; o.off = SIXTH5;
      end else begin
        o.s = ONE - b; x = g; o.off = '0;
      end
    end else begin
      o.v = g;
      if (b > g) begin
        o.v = b; o.s = ONE - r; x = b; o.off = SIXTH2;
      end else if (b > r) begin
        o.s = ONE - r; x = ONE - g; o.off = SIXTH3;
      end else begin
        o.s = ONE - b; x = ONE - r; o.off = SIXTH1;
      end
    end
    o.y = x + unit_t'(3);
    return o;
  endfunction

  function automatic unit_t div6_q(unit_t y);
    prod_t p;
    p = prod_t'(y) * prod_t'(DIV6_MV);
    return unit_t'(p >> DIV6_SH);
  endfunction

  // a*b/ONE rounding half up, for a nonnegative product
  function automatic unit_t round_q(prod_t p);
    prod_t t;
    t = p + HALF_P;
    return unit_t'(t >> FRAC_BITS);
  endfunction

  function automatic unit_t clamp_w(wide_t x);
    if (x < 0) return '0;
    if (x > ONE_W) return ONE;
    return unit_t'(x);
  endfunction

  function automatic wide_t times6(wide_t t);
    return (t <<< 2) + (t <<< 1);
  endfunction

  // hue back to pure RGB by sextant
  function automatic trio_t sextant(unit_t h);
    wide_t hw, r, g, b;
    trio_t o;
    hw = wide_t'({4'b0000, h});
    if (h < SIXTH3) begin
      if (h < SIXTH1) begin
        r = ONE_W; g = times6(hw); b = '0;
      end else begin
        g = ONE_W;
        if (h < SIXTH2) begin
          r = ONE_W - times6(hw - wide_t'({4'b0000, SIXTH1})); b = '0;
        end else begin
          r = '0; b = times6(hw - wide_t'({4'b0000, SIXTH2}));
        end
      end
    end else begin
      if (h >= SIXTH5) begin
        r = ONE_W; g = '0; b = ONE_W - times6(hw - wide_t'({4'b0000, SIXTH5}));
      end else begin
        b = ONE_W;
        if (h < SIXTH4) begin
          r = '0; g = ONE_W - times6(hw - wide_t'({4'b0000, SIXTH3}));
        end else begin
          r = times6(hw - wide_t'({4'b0000, SIXTH4})); g = '0;
        end
      end
    end
    o[0] = clamp_w(r);
    o[1] = clamp_w(g);
    o[2] = clamp_w(b);
    return o;
  endfunction

endpackage

@@ sv/rgb_color_tween_via_hue_top.sv @@
// RGB color tween through the hue wheel: ten-stage pipeline, top level.
//
// Blends two RGB colors (Q1.15, 32768 = 1.0, inputs above 1.0 saturate) by
// blend_factor: each color goes to hue/saturation/brightness by the simplified
// six-case rule, hue is blended around the wheel in the direction set by the
// one config bit (0 = red->green->blue, 1 = reverse) with wrap at 1.0,
// saturation and brightness blend linearly, and the blend goes back to RGB by
// sextant. One transaction is accepted per clock unless a stalled output has
// filled the pipeline. A result passes through the ten register stages:
// operand select, divide-by-six multiply, differences, blend multiply, hue
// wrap, sextant, saturation multiply, saturation rounding, brightness
// multiply, rounding. Valid bits
// travel with the data and a stage that is empty takes new data even while
// the output is stalled, so bubbles squeeze out under backpressure. Write
// hue_direction only while the pipeline is empty; cfg_ready is always high.
module rgb_color_tween_via_hue_top (
  input  logic        clk,
  input  logic        rst,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data,
  // input transaction
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] first_red,
  input  logic [15:0] first_green,
  input  logic [15:0] first_blue,
  input  logic [15:0] second_red,
  input  logic [15:0] second_green,
  input  logic [15:0] second_blue,
  input  logic [15:0] blend_factor,
  // output transaction
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out
);

  localparam int NS = rgbct_pkg::NS;

  logic hue_direction;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      hue_direction <= cfg_data[0];
    end
  end

  // ---------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its
  // successor loads.
  // ---------------------------------------------------------------
  logic [NS:1] vld;
  logic [NS:1] en;
  logic [NS:1] vld_in;

  always_comb begin
    en[NS] = !vld[NS] || out_ready;
    for (int i = NS - 1; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign vld_in   = {vld[NS-1:1], in_valid};
  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld_in & en) | (vld & ~en);
    end
  end

  // Stage 1: saturate, pick the six-case operands
  rgbct_pkg::hsel_t p1_a, p1_b;
  rgbct_pkg::unit_t p1_f;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1_a <= rgbct_pkg::hsv_select(rgbct_pkg::sat_in(first_red),
                                    rgbct_pkg::sat_in(first_green),
                                    rgbct_pkg::sat_in(first_blue));
      p1_b <= rgbct_pkg::hsv_select(rgbct_pkg::sat_in(second_red),
                                    rgbct_pkg::sat_in(second_green),
                                    rgbct_pkg::sat_in(second_blue));
      p1_f <= rgbct_pkg::sat_in(blend_factor);
    end
  end

  // Stage 2: hue = y/6 + sextant offset
  rgbct_pkg::unit_t p2_h1, p2_s1, p2_v1, p2_h2, p2_s2, p2_v2, p2_f;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2_h1 <= rgbct_pkg::div6_q(p1_a.y) + p1_a.off;
      p2_h2 <= rgbct_pkg::div6_q(p1_b.y) + p1_b.off;
      p2_s1 <= p1_a.s;
      p2_v1 <= p1_a.v;
      p2_s2 <= p1_b.s;
      p2_v2 <= p1_b.v;
      p2_f  <= p1_f;
    end
  end

  // Stage 3: differences as magnitude and sign
  rgbct_pkg::unit_t p3_h1, p3_s1, p3_v1, p3_dh, p3_ds, p3_dv, p3_f;
  logic             p3_hsub, p3_sneg, p3_vneg;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p3_h1   <= p2_h1;
      p3_s1   <= p2_s1;
      p3_v1   <= p2_v1;
      p3_f    <= p2_f;
      p3_hsub <= hue_direction;
      if (!hue_direction) begin
        p3_dh <= (p2_h2 >= p2_h1) ? p2_h2 - p2_h1
                                  : rgbct_pkg::ONE - (p2_h1 - p2_h2);
      end else begin
        p3_dh <= (p2_h1 >= p2_h2) ? p2_h1 - p2_h2
                                  : rgbct_pkg::ONE - (p2_h2 - p2_h1);
      end
      p3_sneg <= p2_s2 < p2_s1;
      p3_ds   <= (p2_s2 < p2_s1) ? p2_s1 - p2_s2 : p2_s2 - p2_s1;
      p3_vneg <= p2_v2 < p2_v1;
      p3_dv   <= (p2_v2 < p2_v1) ? p2_v1 - p2_v2 : p2_v2 - p2_v1;
    end
  end

  // Stage 4: blend products
  rgbct_pkg::prod_t p4_ph, p4_ps, p4_pv;
  rgbct_pkg::unit_t p4_h1, p4_s1, p4_v1;
  logic             p4_hsub, p4_sneg, p4_vneg;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      p4_ph   <= rgbct_pkg::prod_t'(p3_f) * rgbct_pkg::prod_t'(p3_dh);
      p4_ps   <= rgbct_pkg::prod_t'(p3_f) * rgbct_pkg::prod_t'(p3_ds);
      p4_pv   <= rgbct_pkg::prod_t'(p3_f) * rgbct_pkg::prod_t'(p3_dv);
      p4_h1   <= p3_h1;
      p4_s1   <= p3_s1;
      p4_v1   <= p3_v1;
      p4_hsub <= p3_hsub;
      p4_sneg <= p3_sneg;
      p4_vneg <= p3_vneg;
    end
  end

  // Stage 5: round, apply, wrap hue, clamp s and v
  rgbct_pkg::wide_t h5_w, s5_w, v5_w;
  rgbct_pkg::wide_t sc_h, sc_s, sc_v;

  always_comb begin
    sc_h = rgbct_pkg::wide_t'({4'b0000, rgbct_pkg::round_q(p4_ph)});
    sc_s = rgbct_pkg::wide_t'({4'b0000, rgbct_pkg::round_q(p4_ps)});
    sc_v = rgbct_pkg::wide_t'({4'b0000, rgbct_pkg::round_q(p4_pv)});
    h5_w = rgbct_pkg::wide_t'({4'b0000, p4_h1});
    h5_w = p4_hsub ? h5_w - sc_h : h5_w + sc_h;
    if (h5_w > rgbct_pkg::ONE_W) begin
      h5_w = h5_w - rgbct_pkg::ONE_W;
    end else if (h5_w < 0) begin
      h5_w = h5_w + rgbct_pkg::ONE_W;
    end
    s5_w = rgbct_pkg::wide_t'({4'b0000, p4_s1});
    s5_w = p4_sneg ? s5_w - sc_s : s5_w + sc_s;
    v5_w = rgbct_pkg::wide_t'({4'b0000, p4_v1});
    v5_w = p4_vneg ? v5_w - sc_v : v5_w + sc_v;
  end

  rgbct_pkg::unit_t p5_h, p5_s, p5_v;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p5_h <= rgbct_pkg::clamp_w(h5_w);
      p5_s <= rgbct_pkg::clamp_w(s5_w);
      p5_v <= rgbct_pkg::clamp_w(v5_w);
    end
  end

  // Stage 6: sextant to pure color, complement for the saturation step
  rgbct_pkg::trio_t c6_pure;
  rgbct_pkg::trio_t p6_c;
  rgbct_pkg::unit_t p6_s, p6_v;

  assign c6_pure = rgbct_pkg::sextant(p5_h);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        p6_c[i] <= rgbct_pkg::ONE - c6_pure[i];
      end
      p6_s <= p5_s;
      p6_v <= p5_v;
    end
  end

  // Stage 7: saturation products
  rgbct_pkg::prod_t p7_p [3];
  rgbct_pkg::unit_t p7_v;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) begin
        p7_p[i] <= rgbct_pkg::prod_t'(p6_s) * rgbct_pkg::prod_t'(p6_c[i]);
      end
      p7_v <= p6_v;
    end
  end

  // Stage 8: desaturated channel = ONE - round(s*(ONE-c))
  rgbct_pkg::trio_t p8_c;
  rgbct_pkg::unit_t p8_v;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int i = 0; i < 3; i++) begin
        p8_c[i] <= rgbct_pkg::ONE - rgbct_pkg::round_q(p7_p[i]);
      end
      p8_v <= p7_v;
    end
  end

  // Stage 9: brightness products
  rgbct_pkg::prod_t p9_p [3];

  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int i = 0; i < 3; i++) begin
        p9_p[i] <= rgbct_pkg::prod_t'(p8_v) * rgbct_pkg::prod_t'(p8_c[i]);
      end
    end
  end

  // Stage 10: round into the output register
  rgbct_pkg::trio_t p10_c;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      for (int i = 0; i < 3; i++) begin
        p10_c[i] <= rgbct_pkg::round_q(p9_p[i]);
      end
    end
  end

  assign out_valid = vld[NS];
  assign red_out   = rgbct_pkg::FW'(p10_c[0]);
  assign green_out = rgbct_pkg::FW'(p10_c[1]);
  assign blue_out  = rgbct_pkg::FW'(p10_c[2]);

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[NS] |-> in_ready)
    else $error("input stalled with empty output stage");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (rst)
    vld[5] && !en[5] |=> vld[5])
    else $error("stalled stage lost its transaction");

  a_hue_in_range: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> p5_h <= rgbct_pkg::ONE)
    else $error("blended hue out of range");

  a_out_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (p10_c[0] <= rgbct_pkg::ONE) && (p10_c[1] <= rgbct_pkg::ONE) &&
                  (p10_c[2] <= rgbct_pkg::ONE))
    else $error("output channel above one");

endmodule
